FILE: hdl/s2a_pkg.sv
// Shared types, constants and the scan-set-1 translation table for the keyboard FIFO.
// Depends on nothing; the design files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package s2a_pkg;

    // Character buffer geometry. One slot always stays free.
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_MAX   = 255;

    localparam logic       OP_PUSH   = 1'b0;
    localparam logic       OP_POP    = 1'b1;
    localparam logic [7:0] BREAK_BIT = 8'h80;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Translator result: hit is low for break codes and codes with no entry.
    typedef struct packed {
        logic       hit;
        logic [6:0] code;
    } xlate_t;

    // US layout, make codes only; zero marks no entry.
    function automatic logic [6:0] us_layout(input logic [6:0] sc);
        logic [6:0] c;
        case (sc)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h31;
            7'd3:    c = 7'h32;
            7'd4:    c = 7'h33;
            7'd5:    c = 7'h34;
            7'd6:    c = 7'h35;
            7'd7:    c = 7'h36;
            7'd8:    c = 7'h37;
            7'd9:    c = 7'h38;
            7'd10:   c = 7'h39;
            7'd11:   c = 7'h30;
            7'd12:   c = 7'h2D;
            7'd13:   c = 7'h3D;
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h71;
            7'd17:   c = 7'h77;
            7'd18:   c = 7'h65;
            7'd19:   c = 7'h72;
            7'd20:   c = 7'h74;
            7'd21:   c = 7'h79;
            7'd22:   c = 7'h75;
            7'd23:   c = 7'h69;
            7'd24:   c = 7'h6F;
            7'd25:   c = 7'h70;
            7'd26:   c = 7'h5B;
            7'd27:   c = 7'h5D;
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h61;
            7'd31:   c = 7'h73;
            7'd32:   c = 7'h64;
            7'd33:   c = 7'h66;
            7'd34:   c = 7'h67;
            7'd35:   c = 7'h68;
            7'd36:   c = 7'h6A;
            7'd37:   c = 7'h6B;
            7'd38:   c = 7'h6C;
            7'd39:   c = 7'h3B;
            7'd40:   c = 7'h27;
            7'd41:   c = 7'h60;
            7'd43:   c = 7'h5C;
            7'd44:   c = 7'h7A;
            7'd45:   c = 7'h78;
            7'd46:   c = 7'h63;
            7'd47:   c = 7'h76;
            7'd48:   c = 7'h62;
            7'd49:   c = 7'h6E;
            7'd50:   c = 7'h6D;
            7'd51:   c = 7'h2C;
            7'd52:   c = 7'h2E;
            7'd53:   c = 7'h2F;
            7'd55:   c = 7'h2A;
            7'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/scancode_to_ascii_fifo_unit.sv
// Keyboard front end: scan-set-1 bytes in, ASCII characters out through a circular buffer.
// Latency: the result word appears, with done high, in the cycle after the command is taken.
// Throughput: one command per cycle; busy stays low, set by the single synchronous
// buffer memory, which sees at most one write or one read per command.
// Reset (rst_n, asynchronous, active low) empties the buffer and clears the strobe;
// buffer contents stay undefined until written. The receiver cannot stall results.
// Depends on s2a_pkg and s2a_xlate.
`timescale 1ns / 1ps

module scancode_to_ascii_fifo_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       opcode,
    input  logic [7:0] scan_byte,
    output logic       done,
    output logic [1:0] status,
    output logic [6:0] char_out,
    output logic [7:0] fill_level
);

    // Character store: one synchronous write port, one registered read port.
    logic [6:0] char_mem [s2a_pkg::FIFO_DEPTH];
    logic [6:0] rdata_reg;

    logic [s2a_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [s2a_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [s2a_pkg::CNT_W-1:0] count_reg, count_next;

    logic              done_reg;
    logic              pop_ok_reg, pop_ok_next;
    s2a_pkg::status_t  status_reg, status_next;
    logic [7:0]        fill_reg, fill_next;

    logic              accept;
    logic              empty;
    logic              full;
    logic              mem_wr;
    logic              mem_rd;
    s2a_pkg::xlate_t   xl;

    s2a_xlate u_xlate (
        .scan_byte (scan_byte),
        .xl        (xl)
    );

    // Every command touches at most one memory port, so no read can meet a write
    // to the same slot: no forwarding needed and never a stall.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == s2a_pkg::CNT_W'(s2a_pkg::FIFO_DEPTH - 1));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_ok_next = 1'b0;
        mem_wr      = 1'b0;
        mem_rd      = 1'b0;
        if (accept)
        begin
            if (opcode == s2a_pkg::OP_PUSH)
            begin
                if (!xl.hit)
                begin
                    // Drop break and unmapped codes.
                    status_next = s2a_pkg::ST_IGNORED;
                end
                else if (full)
                begin
                    status_next = s2a_pkg::ST_FULL;
                end
                else
                begin
                    mem_wr      = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == s2a_pkg::PTR_W'(s2a_pkg::FIFO_DEPTH - 1))
                                  ? '0 : wr_ptr_reg + s2a_pkg::PTR_W'(1);
                    count_next  = count_reg + s2a_pkg::CNT_W'(1);
                    status_next = s2a_pkg::ST_OK;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = s2a_pkg::ST_EMPTY;
                end
                else
                begin
                    // Read the oldest slot; data lands in rdata_reg with the result.
                    mem_rd      = 1'b1;
                    pop_ok_next = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == s2a_pkg::PTR_W'(s2a_pkg::FIFO_DEPTH - 1))
                                  ? '0 : rd_ptr_reg + s2a_pkg::PTR_W'(1);
                    count_next  = count_reg - s2a_pkg::CNT_W'(1);
                    status_next = s2a_pkg::ST_OK;
                end
            end
        end
        // Saturate the reported level for buffers deeper than the field.
        if (32'(count_next) > 32'(s2a_pkg::FILL_MAX))
            fill_next = 8'(s2a_pkg::FILL_MAX);
        else
            fill_next = 8'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            char_mem[wr_ptr_reg] <= xl.code;
        if (mem_rd)
            rdata_reg <= char_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            pop_ok_reg <= 1'b0;
            status_reg <= s2a_pkg::ST_OK;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            done_reg   <= accept;
            pop_ok_reg <= pop_ok_next;
            status_reg <= status_next;
            fill_reg   <= fill_next;
        end
    end

    // Status and fill stay until the next result; char_out is nonzero only with done.
    assign done       = done_reg;
    assign status     = status_reg;
    assign char_out   = pop_ok_reg ? rdata_reg : 7'h00;
    assign fill_level = fill_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= s2a_pkg::FIFO_DEPTH - 1)
        else $error("fill count beyond buffer capacity");

    a_done_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("command taken without a result strobe");

    a_pop_char: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok_reg |-> (done && char_out != 7'h00 && status == s2a_pkg::ST_OK))
        else $error("successful pop returned no character");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg >= rd_ptr_reg)
            ? (32'(wr_ptr_reg) - 32'(rd_ptr_reg) == 32'(count_reg))
            : (32'(wr_ptr_reg) + s2a_pkg::FIFO_DEPTH - 32'(rd_ptr_reg) == 32'(count_reg)))
        else $error("pointers disagree with fill count");
`endif

endmodule

FILE: hdl/s2a_xlate.sv
// Scan byte translator: drops break codes and maps make codes to ASCII.
// Depends on s2a_pkg for the layout table and the xlate_t result type.
`timescale 1ns / 1ps

module s2a_xlate (
    input  logic [7:0]      scan_byte,
    output s2a_pkg::xlate_t xl
);

    logic [6:0] code;

    assign code    = s2a_pkg::us_layout(scan_byte[6:0]);
    // Drop break codes and empty table entries.
    assign xl.hit  = ((scan_byte & s2a_pkg::BREAK_BIT) == 8'h00) && (code != 7'h00);
    assign xl.code = code;

endmodule

FILE: sim/scancode_to_ascii_fifo_unit_tb.sv
// Self-checking testbench for the scan-set-1 keyboard FIFO: directed table, then random
// push/pop phases, every result word checked by a scoreboard against the typed word or the predictor.
// Depends on s2a_pkg and the scancode_to_ascii_fifo_unit RTL.
`timescale 1ns / 1ps

module scancode_to_ascii_fifo_unit_tb;

    import s2a_pkg::*;

    localparam int ITEM_GOAL  = 1450;
    localparam int QUIET_FROM = 1250;   // no sender gaps after this many counted words
    localparam int N_DIRECTED = 25;

    typedef struct packed {
        status_t    st;
        logic [6:0] ch;
        logic [7:0] fill;
    } key_word_t;

    typedef struct packed {
        bit         typed;              // high: compare against want, not the predictor
        logic       op;
        logic [7:0] sc;
        key_word_t  want;
    } stim_row_t;

    localparam key_word_t NO_WORD = '{ST_OK, 7'h00, 8'd0};

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       opcode;
    logic [7:0] scan_byte;
    logic       done;
    logic [1:0] status;
    logic [6:0] char_out;
    logic [7:0] fill_level;

    // Predictor state: translation table, character slots and the two slot indexes.
    byte unsigned keymap [128];
    logic [6:0]   held_chars [FIFO_DEPTH];
    int           wr_slot;
    int           rd_slot;

    // Result words still owed by the block, oldest first.
    key_word_t    awaited_words [$];
    int           error_count;

    stim_row_t    directed_rows [N_DIRECTED];

    scancode_to_ascii_fifo_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .scan_byte  (scan_byte),
        .done       (done),
        .status     (status),
        .char_out   (char_out),
        .fill_level (fill_level)
    );

    always #10 clk = ~clk;

    // Build the US layout independently: rows of the main block plus the odd keys.
    initial
    begin
        string digit_row;
        string upper_row;
        string home_row;
        string lower_row;
        digit_row = "1234567890-=";
        upper_row = "qwertyuiop[]";
        home_row  = "asdfghjkl;'";
        lower_row = "zxcvbnm,./";
        for (int i = 0; i < 128; i++)
            keymap[i] = 8'h00;
        for (int i = 0; i < digit_row.len(); i++)
            keymap[2 + i] = digit_row[i];
        for (int i = 0; i < upper_row.len(); i++)
            keymap[16 + i] = upper_row[i];
        for (int i = 0; i < home_row.len(); i++)
            keymap[30 + i] = home_row[i];
        for (int i = 0; i < lower_row.len(); i++)
            keymap[44 + i] = lower_row[i];
        keymap[1]  = 8'h1B;     // escape
        keymap[14] = 8'h08;     // backspace
        keymap[15] = 8'h09;     // tab
        keymap[28] = 8'h0A;     // enter
        keymap[41] = 8'h60;     // backtick
        keymap[43] = 8'h5C;     // backslash
        keymap[55] = 8'h2A;     // keypad star
        keymap[57] = 8'h20;     // space
    end

    // Advance the predictor by one accepted command and return the word it owes.
    function automatic key_word_t step_keyboard(input logic op, input logic [7:0] sc);
        key_word_t    w;
        byte unsigned entry;
        logic [6:0]   ascii;
        int           held;
        w     = NO_WORD;
        entry = keymap[sc[6:0]];
        ascii = entry[6:0];
        if (op == OP_PUSH)
        begin
            // Drop break codes and codes with no table entry; keep one slot free.
            if (sc[7] || ascii == 7'h00)
                w.st = ST_IGNORED;
            else if ((wr_slot + 1) % FIFO_DEPTH == rd_slot)
                w.st = ST_FULL;
            else
            begin
                held_chars[wr_slot] = ascii;
                wr_slot = (wr_slot + 1) % FIFO_DEPTH;
            end
        end
        else if (wr_slot == rd_slot)
            w.st = ST_EMPTY;
        else
        begin
            w.ch    = held_chars[rd_slot];
            rd_slot = (rd_slot + 1) % FIFO_DEPTH;
        end
        held   = (wr_slot + FIFO_DEPTH - rd_slot) % FIFO_DEPTH;
        w.fill = 8'((held > FILL_MAX) ? FILL_MAX : held);
        return w;
    endfunction

    // Present one command at the falling edge and hold it until the block takes it.
    // Queue either the typed word or the predicted one; the predictor always advances.
    task automatic issue(input logic op, input logic [7:0] sc, input bit typed,
                         input key_word_t typed_word, output key_word_t predicted);
        @(negedge clk);
        start     <= 1'b1;
        opcode    <= op;
        scan_byte <= sc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = step_keyboard(op, sc);
        awaited_words.push_back(typed ? typed_word : predicted);
    endtask

    // Drop start for a gap set by n; scramble the payload so a stray capture shows up.
    task automatic hold_off(input int n);
        @(negedge clk);
        start     <= 1'b0;
        opcode    <= 1'($urandom);
        scan_byte <= 8'($urandom);
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Drop start and wait until every owed word has come back.
    task automatic wait_for_drain();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
    endtask

    // Scoreboard: each strobed word must match the oldest owed word, field by field.
    always @(posedge clk)
    begin
        key_word_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_words.size() == 0)
            begin
                if (error_count < 10)
                    $display("%0t: word with nothing owed: status %0d char %h fill %0d",
                             $realtime, status, char_out, fill_level);
                error_count++;
            end
            else
            begin
                want = awaited_words.pop_front();
                if (status !== want.st || char_out !== want.ch || fill_level !== want.fill)
                begin
                    if (error_count < 10)
                        $display("%0t: mismatch: want status %0d char %h fill %0d, got %0d %h %0d",
                                 $realtime, want.st, want.ch, want.fill,
                                 status, char_out, fill_level);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        key_word_t  w;
        logic       op;
        logic [7:0] sc;
        int         real_items;
        int         phase;
        int         len;
        int         push_pct;
        int         kind;
        bit         first_phase;

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_PUSH;
        scan_byte   = 8'h00;
        wr_slot     = 0;
        rd_slot     = 0;
        error_count = 0;
        real_items  = 0;
        first_phase = 1'b1;

        // Typed rows: empty pop after reset, ignored codes at the byte extremes, one push/pop
        // round trip and an empty pop after it. The rest relies on the predictor.
        directed_rows = '{
            '{1'b1, OP_POP,  8'h00, '{ST_EMPTY,   7'h00, 8'd0}},
            '{1'b1, OP_PUSH, 8'h00, '{ST_IGNORED, 7'h00, 8'd0}},
            '{1'b1, OP_PUSH, 8'hFF, '{ST_IGNORED, 7'h00, 8'd0}},
            '{1'b1, OP_PUSH, 8'h80, '{ST_IGNORED, 7'h00, 8'd0}},
            '{1'b1, OP_PUSH, 8'h7F, '{ST_IGNORED, 7'h00, 8'd0}},
            '{1'b1, OP_PUSH, 8'h1E, '{ST_OK,      7'h00, 8'd1}},
            '{1'b1, OP_POP,  8'hFF, '{ST_OK,      7'h61, 8'd0}},
            '{1'b1, OP_POP,  8'h55, '{ST_EMPTY,   7'h00, 8'd0}},
            '{1'b0, OP_PUSH, 8'h01, NO_WORD},
            '{1'b0, OP_PUSH, 8'h39, NO_WORD},
            '{1'b0, OP_PUSH, 8'h3A, NO_WORD},
            '{1'b0, OP_PUSH, 8'h1D, NO_WORD},
            '{1'b0, OP_PUSH, 8'h9E, NO_WORD},
            '{1'b0, OP_PUSH, 8'h0E, NO_WORD},
            '{1'b0, OP_PUSH, 8'h0F, NO_WORD},
            '{1'b0, OP_PUSH, 8'h1C, NO_WORD},
            '{1'b0, OP_PUSH, 8'h2B, NO_WORD},
            '{1'b0, OP_PUSH, 8'h28, NO_WORD},
            '{1'b0, OP_PUSH, 8'h37, NO_WORD},
            '{1'b0, OP_POP,  8'hAA, NO_WORD},
            '{1'b0, OP_POP,  8'h01, NO_WORD},
            '{1'b0, OP_POP,  8'h80, NO_WORD},
            '{1'b0, OP_POP,  8'h7F, NO_WORD},
            '{1'b0, OP_POP,  8'h33, NO_WORD},
            '{1'b0, OP_POP,  8'hCC, NO_WORD}
        };

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            issue(directed_rows[i].op, directed_rows[i].sc, directed_rows[i].typed,
                  directed_rows[i].want, w);
            real_items++;
        end

        // Hold the sender until the block has answered everything.
        wait_for_drain();

        // Random phases: fill (mostly mapped pushes, runs into full), drain (mostly pops,
        // runs into empty) and mixed. Start with a fill so the full case is always hit.
        while (real_items < ITEM_GOAL)
        begin
            phase       = first_phase ? 0 : $urandom_range(0, 2);
            first_phase = 1'b0;
            case (phase)
                0:       begin len = $urandom_range(380, 450); push_pct = 95; end
                1:       begin len = $urandom_range(20, 300);  push_pct = 10; end
                default: begin len = $urandom_range(30, 80);   push_pct = 50; end
            endcase
            if (real_items < QUIET_FROM && $urandom_range(0, 3) == 0)
                wait_for_drain();
            for (int i = 0; i < len && real_items < ITEM_GOAL; i++)
            begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                sc = 8'($urandom_range(0, 255));
                if (op == OP_PUSH)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind < 7 || (phase == 0 && kind < 9))
                    begin
                        // Well-formed make code with a table entry.
                        do
                            sc = 8'($urandom_range(0, 127));
                        while (keymap[sc[6:0]] == 8'h00);
                    end
                    else if (kind < 9)
                        sc = 8'($urandom_range(128, 255));
                    else
                        sc = 8'($urandom_range(0, 127));
                end
                if (real_items < QUIET_FROM && $urandom_range(0, 5) == 0)
                    hold_off($urandom_range(1, 11));
                issue(op, sc, 1'b0, NO_WORD, w);
                real_items++;
            end
        end

        // Let the last words come back, then keep watching for stray strobes before the verdict.
        wait_for_drain();
        repeat (4)
            @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
